[rtl/assert_macros.svh]
// Assertion helpers used by the RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define RIOFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define RIOFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/riofp_pkg.sv]
package riofp_pkg;

  // Default largest accepted payload length
  localparam int DEF_MAX_PAYLOAD = 24;

  // Framing bytes
  localparam logic [7:0] START_BYTE     = 8'h7E;
  localparam logic [7:0] KIND_IO_SAMPLE = 8'h92;
  localparam logic [7:0] SUM_BASE       = 8'hFF;

  // Payload offsets of the kept bytes
  localparam int OFS_KIND   = 0;
  localparam int OFS_COUNT  = 12;
  localparam int OFS_MASK   = 14;
  localparam int OFS_SAMPLE = 17;

  // Per-item frame status code
  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_APPLIED = 3'd1,
    ST_IGNORED = 3'd2,
    ST_BAD_SUM = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_t;

endpackage

[rtl/radio_io_frame_parser_unit.sv]
// Channel | Signals                                        | Role
// rx      | rx_valid rx_stall rx_byte                      | bytes in
// res     | res_valid res_stall latch_value frame_status   | one result item per byte
//
// One byte is taken per cycle while rx_stall is low; the result register holds
// its result from the next cycle. The frame state update is a single pass of
// logic from the state registers and the byte into the state and result
// registers. Synchronous active-high reset puts the parser in the start-byte
// hunt and clears the latch and kept bytes. rx_stall rises only while a result
// waits and res_stall is high, so a byte is accepted in the cycle the result drains.
`include "assert_macros.svh"

module radio_io_frame_parser_unit #(
  parameter int MAX_PAYLOAD = riofp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] latch_value,
  output logic [2:0] frame_status
);
  import riofp_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    len_hi, len_hi_next;
  logic [CW-1:0] frame_len, frame_len_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    kind_byte, kind_byte_next;
  logic [7:0]    sample_count_byte, sample_count_byte_next;
  logic [7:0]    mask_byte, mask_byte_next;
  logic [7:0]    sample_byte, sample_byte_next;
  logic [7:0]    latched, latched_next;
  status_t       status_next;

  logic          acc;
  logic [15:0]   full_len;
  logic [CW:0]   cnt_inc;
  logic          chk_status_ok;

  // Accept whenever the result register is free or drains this cycle
  assign rx_stall = res_valid && res_stall;
  assign acc      = rx_valid && !rx_stall;

  assign full_len = {len_hi, rx_byte};
  assign cnt_inc  = {1'b0, byte_count} + {{CW{1'b0}}, 1'b1};

  // Per-byte parser update
  always_comb begin
    phase_next             = phase;
    len_hi_next            = len_hi;
    frame_len_next         = frame_len;
    byte_count_next        = byte_count;
    running_sum_next       = running_sum;
    kind_byte_next         = kind_byte;
    sample_count_byte_next = sample_count_byte;
    mask_byte_next         = mask_byte;
    sample_byte_next       = sample_byte;
    latched_next           = latched;
    status_next            = ST_NONE;
    case (phase)
      PH_LEN_HI: begin
        len_hi_next = rx_byte;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        // zero or oversize length is dropped
        if (full_len == 16'd0 || full_len > 16'(MAX_PAYLOAD)) begin
          status_next = ST_BAD_LEN;
          phase_next  = PH_HUNT;
        end else begin
          frame_len_next = full_len[CW-1:0];
          phase_next     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_count == CW'(OFS_KIND)) begin
          kind_byte_next = rx_byte;
        end else if (byte_count == CW'(OFS_COUNT)) begin
          sample_count_byte_next = rx_byte;
        end else if (byte_count == CW'(OFS_MASK)) begin
          mask_byte_next = rx_byte;
        end else if (byte_count == CW'(OFS_SAMPLE)) begin
          sample_byte_next = rx_byte;
        end
        byte_count_next  = cnt_inc[CW-1:0];
        running_sum_next = running_sum + rx_byte;
        if (cnt_inc >= {1'b0, frame_len}) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte == SUM_BASE - running_sum) begin
          if (kind_byte == KIND_IO_SAMPLE && sample_count_byte == 8'd1) begin
            latched_next = ~sample_byte & mask_byte;
            status_next  = ST_APPLIED;
          end else begin
            status_next = ST_IGNORED;
          end
        end else begin
          status_next = ST_BAD_SUM;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        // hunt for the start byte
        phase_next = PH_HUNT;
        if (rx_byte == START_BYTE) begin
          byte_count_next  = '0;
          running_sum_next = 8'd0;
          phase_next       = PH_LEN_HI;
        end
      end
    endcase
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      len_hi            <= 8'd0;
      frame_len         <= '0;
      byte_count        <= '0;
      running_sum       <= 8'd0;
      kind_byte         <= 8'd0;
      sample_count_byte <= 8'd0;
      mask_byte         <= 8'd0;
      sample_byte       <= 8'd0;
      latched           <= 8'd0;
      res_valid         <= 1'b0;
    end else if (acc) begin
      phase             <= phase_next;
      len_hi            <= len_hi_next;
      frame_len         <= frame_len_next;
      byte_count        <= byte_count_next;
      running_sum       <= running_sum_next;
      kind_byte         <= kind_byte_next;
      sample_count_byte <= sample_count_byte_next;
      mask_byte         <= mask_byte_next;
      sample_byte       <= sample_byte_next;
      latched           <= latched_next;
      res_valid         <= 1'b1;
      latch_value       <= latched_next;
      frame_status      <= status_next;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Checks
  // a checksum byte always ends with one of the checksum verdicts
  assign chk_status_ok = frame_status == ST_APPLIED || frame_status == ST_IGNORED ||
                         frame_status == ST_BAD_SUM;

  `RIOFP_ASSERT_NXT(a_check_status, acc && phase == PH_CHECK, res_valid && chk_status_ok)
  `RIOFP_ASSERT_NXT(a_latch_hold, acc && phase != PH_CHECK, latched == $past(latched))
  `RIOFP_ASSERT_IMP(a_count_range, phase == PH_PAYLOAD, byte_count < frame_len && frame_len != '0)

endmodule

[test/riofp_checker.sv]
module riofp_checker #(
  parameter int MAX_LEN = riofp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [7:0] latch_value,
  input  logic [2:0] frame_status,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import riofp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] latch;
    status_t    status;
  } byte_result_t;

  // Parser state mirrored from the block
  parse_phase_t phase;
  logic [15:0]  declared_len;
  logic [7:0]   payload_idx;
  logic [7:0]   payload_sum;
  logic [7:0]   kind_seen;
  logic [7:0]   count_seen;
  logic [7:0]   mask_seen;
  logic [7:0]   sample_seen;
  logic [7:0]   latch_model;

  byte_result_t expected_byte_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Advance the frame parser by one received byte
  task automatic parse_byte(input logic [7:0] b, output byte_result_t r);
    status_t st;
    st = ST_NONE;
    case (phase)
      PH_LEN_HI: begin
        declared_len = {b, 8'h00};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        declared_len[7:0] = b;
        if (declared_len == 16'd0 || declared_len > 16'(MAX_LEN)) begin
          st = ST_BAD_LEN;
          phase = PH_HUNT;
        end else begin
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // only four payload offsets are kept; others leave stale values
        case (payload_idx)
          8'(OFS_KIND):   kind_seen = b;
          8'(OFS_COUNT):  count_seen = b;
          8'(OFS_MASK):   mask_seen = b;
          8'(OFS_SAMPLE): sample_seen = b;
          default: ;
        endcase
        payload_idx = payload_idx + 8'd1;
        payload_sum = payload_sum + b;
        if ({8'h00, payload_idx} >= declared_len) phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == SUM_BASE - payload_sum) begin
          if (kind_seen == KIND_IO_SAMPLE && count_seen == 8'd1) begin
            latch_model = ~sample_seen & mask_seen;
            st = ST_APPLIED;
          end else begin
            st = ST_IGNORED;
          end
        end else begin
          st = ST_BAD_SUM;
        end
        phase = PH_HUNT;
      end
      default: begin
        phase = PH_HUNT;
        if (b == START_BYTE) begin
          payload_idx = 8'd0;
          payload_sum = 8'd0;
          phase = PH_LEN_HI;
        end
      end
    endcase
    r.latch  = latch_model;
    r.status = st;
  endtask

  task automatic note_failure(input string what, input byte_result_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t ns: %s: latch exp %h got %h, status exp %0d got %0d", $realtime, what,
               want.latch, latch_value, want.status, frame_status);
  endtask

  // Results are checked before the byte taken at the same edge is predicted
  always @(posedge clk) begin
    byte_result_t want;
    if (rst) begin
      phase        = PH_HUNT;
      declared_len = 16'd0;
      payload_idx  = 8'd0;
      payload_sum  = 8'd0;
      kind_seen    = 8'd0;
      count_seen   = 8'd0;
      mask_seen    = 8'd0;
      sample_seen  = 8'd0;
      latch_model  = 8'd0;
      expected_byte_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_byte_results.size() == 0) begin
          note_failure("result with no byte outstanding", '0);
        end else begin
          want = expected_byte_results.pop_front();
          if (latch_value !== want.latch) note_failure("latch_value mismatch", want);
          else if (frame_status !== want.status) note_failure("frame_status mismatch", want);
        end
      end
      if (rx_valid && !rx_stall) begin
        parse_byte(rx_byte, want);
        expected_byte_results.push_back(want);
      end
    end
    pending_count = expected_byte_results.size();
  end

endmodule

[test/tb_radio_io_frame_parser_unit.sv]
module tb_radio_io_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = riofp_pkg::DEF_MAX_PAYLOAD;
  localparam int BYTE_TARGET = 1600;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 8;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       res_stall = 1'b0;
  logic       rx_stall;
  logic       res_valid;
  logic [7:0] latch_value;
  logic [2:0] frame_status;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int sent_count  = 0;
  bit calm        = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  radio_io_frame_parser_unit #(
    .MAX_PAYLOAD(MAX_LEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .latch_value (latch_value),
    .frame_status(frame_status)
  );

  riofp_checker #(
    .MAX_LEN(MAX_LEN)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .latch_value  (latch_value),
    .frame_status (frame_status),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL radio_io_frame_parser_unit");
      $finish;
    end
  end

  // Result side back-pressure: stretches of varying stall density
  initial begin
    int stretch;
    int stall_pct;
    stretch   = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(200, 10);
        case ($urandom_range(4, 0))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: begin
            stall_pct = 100;
            stretch   = $urandom_range(60, 15);
          end
        endcase
      end
      stretch--;
      res_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Idle cycles before a byte: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  // Called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    if (counted) sent_count++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_byte(riofp_pkg::START_BYTE, 1'b1);
    send_byte(len[15:8], 1'b1);
    send_byte(len[7:0], 1'b1);
  endtask

  // Full frame; kept fields land only where the length reaches them
  task automatic send_frame(input int body_len, input logic [7:0] kind,
                            input logic [7:0] count, input bit bad_sum);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] chk;
    sum = 8'h00;
    for (int i = 0; i < body_len; i++) body.push_back(8'($urandom));
    if (body_len > riofp_pkg::OFS_KIND)  body[riofp_pkg::OFS_KIND]  = kind;
    if (body_len > riofp_pkg::OFS_COUNT) body[riofp_pkg::OFS_COUNT] = count;
    send_header(16'(body_len));
    foreach (body[i]) begin
      sum = sum + body[i];
      send_byte(body[i], 1'b1);
    end
    chk = riofp_pkg::SUM_BASE - sum;
    if (bad_sum) chk = chk ^ 8'($urandom_range(255, 1));
    send_byte(chk, 1'b1);
  endtask

  task automatic wait_for_results();
    rx_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    logic [7:0] kind;
    logic [7:0] count;
    bit drained;
    drained = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: noise while hunting, rejected lengths, short frames
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_header(16'h0000);
    send_header(16'h0100);
    send_header(16'(MAX_LEN + 1));
    send_frame(1, riofp_pkg::KIND_IO_SAMPLE, 8'd1, 1'b0);
    send_frame(1, 8'h00, 8'd0, 1'b1);
    // start byte taken as the high length byte
    send_byte(riofp_pkg::START_BYTE, 1'b1);
    send_byte(riofp_pkg::START_BYTE, 1'b1);
    send_byte(8'h00, 1'b1);

    // Random: mostly well-formed sample frames, plus broken ones and noise
    while (sent_count < BYTE_TARGET) begin
      if ($urandom_range(15, 0) == 0) calm = ~calm;
      if (!drained && sent_count >= BYTE_TARGET / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        kind  = riofp_pkg::KIND_IO_SAMPLE;
        count = 8'd1;
        if ($urandom_range(9, 0) == 0) kind = 8'($urandom);
        if ($urandom_range(9, 0) == 0) count = 8'($urandom_range(3, 0));
        send_frame($urandom_range(MAX_LEN, 18), kind, count, $urandom_range(19, 0) == 0);
      end else if (pick < 75) begin
        send_frame($urandom_range(MAX_LEN, 1), 8'($urandom), 8'($urandom),
                   $urandom_range(3, 0) == 0);
      end else if (pick < 85) begin
        case ($urandom_range(2, 0))
          0: send_header(16'h0000);
          1: send_header({8'h00, 8'($urandom_range(255, MAX_LEN + 1))});
          default: send_header({8'($urandom_range(255, 1)), 8'($urandom)});
        endcase
      end else if (pick < 93) begin
        // truncated frame; later bytes are parsed as its remainder
        send_byte(riofp_pkg::START_BYTE, 1'b1);
        repeat ($urandom_range(4, 0)) send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS radio_io_frame_parser_unit");
    end else begin
      $display("FAIL radio_io_frame_parser_unit");
    end
    $finish;
  end

endmodule
